@@ rtl/psd_pkg.sv @@
package psd_pkg;

    localparam logic [1:0] CASE_DEGEN    = 2'd0;
    localparam logic [1:0] CASE_END_A    = 2'd1;
    localparam logic [1:0] CASE_END_B    = 2'd2;
    localparam logic [1:0] CASE_INTERIOR = 2'd3;

    // Control that travels beside each item through the pipeline.
    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } t_tag;

endpackage

@@ rtl/point_segment_distance_core.sv @@
// Distance from a point C to a line segment AB in two dimensions.
// Input channel (s): one item holds ax, ay, bx, by_coord, px, py as signed
// COORD_BITS integers, packed in i_s_tdata from the lowest bit up.
// Output channel (m): o_m_tdata holds distance_q8, the floor of 2^FRAC_BITS
// times the Euclidean distance; o_m_tuser holds nearest_case (0 degenerate
// segment, 1 endpoint A, 2 endpoint B, 3 interior projection).
// The pipeline holds five front stages (differences, products, case choice,
// squaring of the cross product, numerator), one chain cell per quotient
// bit of the exact division by the squared segment length (by one outside
// the interior case), one cell per root bit, and the output register.
// One item is accepted every cycle while the output is not stalled.
// The whole pipeline advances together. While the output register holds an
// item that the receiver does not take, o_s_tready is low and every stage
// holds; as soon as the receiver takes it, flow resumes with no lost cycle.
// Reset (synchronous, active low) empties the pipeline; the block has no
// other state and needs no setup.
module point_segment_distance_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // ax, ay, bx, by_coord, px, py from bit 0 up, zero-filled to bytes.
    input  logic [((6*COORD_BITS+7)/8)*8-1:0]     i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // distance_q8 from bit 0 up, zero-filled to bytes.
    output logic [((COORD_BITS+FRAC_BITS+8)/8)*8-1:0] o_m_tdata,
    // nearest_case.
    output logic [1:0]                            o_m_tuser
);
    import psd_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int DW  = COORD_BITS + FRAC_BITS + 1;
    localparam int LW  = 2 * COORD_BITS + 2;
    localparam int Q   = 2 * DW;
    localparam int ODW = ((COORD_BITS + FRAC_BITS + 8) / 8) * 8;

    logic w_en;
    logic r_out_valid;
    logic [DW-1:0] r_out_dist;
    logic [1:0]    r_out_code;

    t_tag          w_dtag [0:Q];
    logic [LW-1:0] w_drem [0:Q];
    logic [Q-1:0]  w_dbits[0:Q];
    logic [LW-1:0] w_dden [0:Q];

    t_tag            w_stag [0:DW];
    logic [DW+1:0]   w_srem [0:DW];
    logic [DW-1:0]   w_sroot[0:DW];
    logic [2*DW-1:0] w_srad [0:DW];

    assign w_en       = !r_out_valid || i_m_tready;
    assign o_s_tready = w_en;

    psd_front #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_valid(i_s_tvalid),
        .i_ax   ($signed(i_s_tdata[C-1:0])),
        .i_ay   ($signed(i_s_tdata[2*C-1:C])),
        .i_bx   ($signed(i_s_tdata[3*C-1:2*C])),
        .i_by   ($signed(i_s_tdata[4*C-1:3*C])),
        .i_cx   ($signed(i_s_tdata[5*C-1:4*C])),
        .i_cy   ($signed(i_s_tdata[6*C-1:5*C])),
        .o_tag  (w_dtag[0]),
        .o_rem  (w_drem[0]),
        .o_bits (w_dbits[0]),
        .o_den  (w_dden[0])
    );

    for (genvar g = 0; g < Q; g++) begin : g_div
        psd_div_cell #(
            .LW(LW),
            .Q (Q)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_tag  (w_dtag[g]),
            .i_rem  (w_drem[g]),
            .i_bits (w_dbits[g]),
            .i_den  (w_dden[g]),
            .o_tag  (w_dtag[g+1]),
            .o_rem  (w_drem[g+1]),
            .o_bits (w_dbits[g+1]),
            .o_den  (w_dden[g+1])
        );
    end

    // The quotient is the radicand; its square root is the distance.
    assign w_stag[0]  = w_dtag[Q];
    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_srad[0]  = w_dbits[Q];

    for (genvar g = 0; g < DW; g++) begin : g_sqrt
        psd_sqrt_cell #(
            .DW(DW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_tag  (w_stag[g]),
            .i_rem  (w_srem[g]),
            .i_root (w_sroot[g]),
            .i_rad  (w_srad[g]),
            .o_tag  (w_stag[g+1]),
            .o_rem  (w_srem[g+1]),
            .o_root (w_sroot[g+1]),
            .o_rad  (w_srad[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_stag[DW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_dist <= w_sroot[DW];
            r_out_code <= w_stag[DW].code;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = ODW'(r_out_dist);
    assign o_m_tuser  = r_out_code;

endmodule

@@ rtl/psd_front.sv @@
module psd_front #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [COORD_BITS-1:0]        i_ax,
    input  logic signed [COORD_BITS-1:0]        i_ay,
    input  logic signed [COORD_BITS-1:0]        i_bx,
    input  logic signed [COORD_BITS-1:0]        i_by,
    input  logic signed [COORD_BITS-1:0]        i_cx,
    input  logic signed [COORD_BITS-1:0]        i_cy,
    output psd_pkg::t_tag                       o_tag,
    output logic [2*COORD_BITS+1:0]             o_rem,
    output logic [2*(COORD_BITS+FRAC_BITS+1)-1:0] o_bits,
    output logic [2*COORD_BITS+1:0]             o_den
);
    import psd_pkg::*;

    localparam int D1    = COORD_BITS + 1;
    localparam int P     = 2 * COORD_BITS + 2;
    localparam int SW    = P + 1;
    localparam int LW    = 2 * COORD_BITS + 2;
    localparam int H     = COORD_BITS + 1;
    localparam int NW    = 4 * H;
    localparam int Q     = 2 * (COORD_BITS + FRAC_BITS + 1);
    localparam int W_NUM = NW + 2 * FRAC_BITS;

    logic                 r_v1, r_v2, r_v3, r_v4;
    logic signed [D1-1:0] r_dx, r_dy, r_ex, r_ey, r_fx, r_fy;
    logic signed [P-1:0]  r_dxdx, r_dydy, r_dxex, r_dyey, r_dxey, r_dyex;
    logic signed [P-1:0]  r_exex, r_eyey, r_fxfx, r_fyfy;
    logic [1:0]           r_code3, r_code4;
    logic [LW-1:0]        r_l2_3, r_s3, r_l2_4, r_s4;
    logic [2*H-1:0]       r_cr;
    logic [2*H-1:0]       r_hh, r_hl, r_ll;

    logic [LW-1:0]        n_l2, n_s;
    logic signed [SW-1:0] n_dot, n_cross;
    logic [P-1:0]         n_crmag;
    logic [1:0]           n_code;
    logic [NW-1:0]        n_n;
    logic [W_NUM-1:0]     n_num;

    always_comb begin
        n_l2    = r_dxdx[LW-1:0] + r_dydy[LW-1:0];
        n_dot   = SW'(r_dxex) + SW'(r_dyey);
        n_cross = SW'(r_dxey) - SW'(r_dyex);
        n_crmag = n_cross[SW-1] ? P'(-n_cross) : P'(n_cross);
        if (n_l2 == '0) begin
            n_code = CASE_DEGEN;
            n_s    = r_fxfx[LW-1:0] + r_fyfy[LW-1:0];
        end else if (n_dot[SW-1]) begin
            n_code = CASE_END_A;
            n_s    = r_exex[LW-1:0] + r_eyey[LW-1:0];
        end else if (n_dot > $signed({1'b0, n_l2})) begin
            n_code = CASE_END_B;
            n_s    = r_fxfx[LW-1:0] + r_fyfy[LW-1:0];
        end else begin
            n_code = CASE_INTERIOR;
            n_s    = r_exex[LW-1:0] + r_eyey[LW-1:0];
        end
    end

    // Square of the cross product from three half-width products.
    always_comb begin
        n_n = {r_hh, r_ll} + (NW'(r_hl) << (H + 1));
        if (r_code4 == CASE_INTERIOR) begin
            n_num = W_NUM'(n_n) << (2 * FRAC_BITS);
        end else begin
            n_num = W_NUM'(r_s4) << (2 * FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            o_tag.valid <= 1'b0;
        end else if (i_en) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            o_tag.valid <= r_v4;
            o_tag.code  <= r_code4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx    <= D1'(i_bx) - D1'(i_ax);
            r_dy    <= D1'(i_by) - D1'(i_ay);
            r_ex    <= D1'(i_cx) - D1'(i_ax);
            r_ey    <= D1'(i_cy) - D1'(i_ay);
            r_fx    <= D1'(i_cx) - D1'(i_bx);
            r_fy    <= D1'(i_cy) - D1'(i_by);

            r_dxdx  <= P'(r_dx * r_dx);
            r_dydy  <= P'(r_dy * r_dy);
            r_dxex  <= P'(r_dx * r_ex);
            r_dyey  <= P'(r_dy * r_ey);
            r_dxey  <= P'(r_dx * r_ey);
            r_dyex  <= P'(r_dy * r_ex);
            r_exex  <= P'(r_ex * r_ex);
            r_eyey  <= P'(r_ey * r_ey);
            r_fxfx  <= P'(r_fx * r_fx);
            r_fyfy  <= P'(r_fy * r_fy);

            r_code3 <= n_code;
            r_l2_3  <= n_l2;
            r_s3    <= n_s;
            r_cr    <= n_crmag[2*H-1:0];

            r_code4 <= r_code3;
            r_l2_4  <= r_l2_3;
            r_s4    <= r_s3;
            r_hh    <= r_cr[2*H-1:H] * r_cr[2*H-1:H];
            r_hl    <= r_cr[2*H-1:H] * r_cr[H-1:0];
            r_ll    <= r_cr[H-1:0] * r_cr[H-1:0];

            o_rem      <= n_num[W_NUM-1:Q];
            o_bits     <= n_num[Q-1:0];
            o_den      <= (r_code4 == CASE_INTERIOR) ? r_l2_4 : LW'(1);
        end
    end

endmodule

@@ rtl/psd_div_cell.sv @@
module psd_div_cell #(
    parameter int LW = 34,
    parameter int Q  = 50
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  psd_pkg::t_tag i_tag,
    input  logic [LW-1:0] i_rem,
    input  logic [Q-1:0]  i_bits,
    input  logic [LW-1:0] i_den,
    output psd_pkg::t_tag o_tag,
    output logic [LW-1:0] o_rem,
    output logic [Q-1:0]  o_bits,
    output logic [LW-1:0] o_den
);
    import psd_pkg::*;

    logic [LW:0] n_trial;
    logic        n_ge;
    logic [LW:0] n_diff;

    // One restoring step: numerator bits leave at the top, quotient bits enter below.
    always_comb begin
        n_trial = {i_rem, i_bits[Q-1]};
        n_ge    = n_trial >= {1'b0, i_den};
        n_diff  = n_ge ? (n_trial - {1'b0, i_den}) : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag.valid <= 1'b0;
        end else if (i_en) begin
            o_tag.valid <= i_tag.valid;
            o_tag.code  <= i_tag.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem      <= n_diff[LW-1:0];
            o_bits     <= {i_bits[Q-2:0], n_ge};
            o_den      <= i_den;
        end
    end

endmodule

@@ rtl/psd_sqrt_cell.sv @@
module psd_sqrt_cell #(
    parameter int DW = 25
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  psd_pkg::t_tag   i_tag,
    input  logic [DW+1:0]   i_rem,
    input  logic [DW-1:0]   i_root,
    input  logic [2*DW-1:0] i_rad,
    output psd_pkg::t_tag   o_tag,
    output logic [DW+1:0]   o_rem,
    output logic [DW-1:0]   o_root,
    output logic [2*DW-1:0] o_rad
);
    import psd_pkg::*;

    logic [DW+3:0] n_cur;
    logic [DW+3:0] n_trial;
    logic          n_ge;
    logic [DW+3:0] n_diff;

    // One root bit per cell: bring down two radicand bits, try root*4+1.
    always_comb begin
        n_cur   = {i_rem, i_rad[2*DW-1:2*DW-2]};
        n_trial = (DW + 4)'({i_root, 2'b01});
        n_ge    = n_cur >= n_trial;
        n_diff  = n_ge ? (n_cur - n_trial) : n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag.valid <= 1'b0;
        end else if (i_en) begin
            o_tag.valid <= i_tag.valid;
            o_tag.code  <= i_tag.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem      <= n_diff[DW+1:0];
            o_root     <= {i_root[DW-2:0], n_ge};
            o_rad      <= i_rad << 2;
        end
    end

endmodule

@@ rtl/psd_checker.sv @@
module psd_checker #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input logic                                      i_clk,
    input logic                                      i_rst_n,
    input logic                                      i_s_tvalid,
    input logic                                      o_s_tready,
    input logic [((6*COORD_BITS+7)/8)*8-1:0]         i_s_tdata,
    input logic                                      o_m_tvalid,
    input logic                                      i_m_tready,
    input logic [((COORD_BITS+FRAC_BITS+8)/8)*8-1:0] o_m_tdata,
    input logic [1:0]                                o_m_tuser
);
    import psd_pkg::*;

    // Reset empties the pipeline, so nothing is offered in the next cycle.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // With the output register empty, the pipeline always moves.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input not ready with empty output");

    // A stalled output freezes the pipeline, so no new item may enter.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input ready while output stalled");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=>
            (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))
        else $error("stalled output item changed");

endmodule

bind point_segment_distance_core psd_checker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_psd_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .i_s_tdata (i_s_tdata),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tuser (o_m_tuser)
);
